### design/b64sd_pkg.sv
// Package for the streaming base64 decoder: beat types, the job record passed
// from the front end to the back end, character constants and the sextet lookup.
// No dependencies.
package b64sd_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_SLASH   = 8'h2F;

    typedef struct packed {
        logic [7:0] char_code;
        logic       string_end;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       output_end;
    } out_beat_t;

    // One accepted character's worth of output: up to three bytes, oldest in
    // slot 0. A job with no bytes is an empty end marker and always has last set.
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      nbytes;
        logic            last;
    } job_t;

    // Returns {ok, value}; ok is low for '=' and any byte outside the alphabet.
    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [6:0] r;
        begin
            r = '0;
            if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
            begin
                r = {1'b1, 6'(c - CHAR_UPPER_A)};
            end
            else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z)
            begin
                r = {1'b1, 6'(c - CHAR_LOWER_A + 8'd26)};
            end
            else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9)
            begin
                r = {1'b1, 6'(c - CHAR_DIGIT_0 + 8'd52)};
            end
            else if (c == CHAR_PLUS)
            begin
                r = {1'b1, 6'd62};
            end
            else if (c == CHAR_SLASH)
            begin
                r = {1'b1, 6'd63};
            end
            return r;
        end
    endfunction

endpackage

### design/b64sd_front.sv
// Base64 decoder front end (uses b64sd_pkg): accepts characters, collects
// sextets and queues a job for each one that yields bytes or ends a string.
module b64sd_front import b64sd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    output logic     full,
    input  in_beat_t item,
    input  logic     queue_full,
    output logic     job_push,
    output job_t     job
);

    logic [17:0] sextet_buf_reg, sextet_buf_next;
    logic [1:0]  count_reg, count_next;
    logic        halted_reg, halted_next;

    logic        accept;
    logic [6:0]  lookup;
    logic [23:0] word;

    assign full   = queue_full;
    assign accept = push && !queue_full;
    assign lookup = sextet_of(item.char_code);
    assign word   = {sextet_buf_reg, lookup[5:0]};

    always_comb
    begin
        sextet_buf_next = sextet_buf_reg;
        count_next      = count_reg;
        halted_next     = halted_reg;
        job             = '0;
        job_push        = 1'b0;

        if (!halted_reg)
        begin
            if (!lookup[6])
            begin
                halted_next = 1'b1;
            end
            else if (count_reg == 2'd3)
            begin
                // Fourth sextet closes the group: three bytes, high byte first.
                job.bytes[0]    = word[23:16];
                job.bytes[1]    = word[15:8];
                job.bytes[2]    = word[7:0];
                job.nbytes      = 2'd3;
                sextet_buf_next = '0;
                count_next      = 2'd0;
            end
            else
            begin
                sextet_buf_next = {sextet_buf_reg[11:0], lookup[5:0]};
                count_next      = count_reg + 2'd1;
            end
        end

        if (item.string_end)
        begin
            // Flush a partial group; a lone sextet gives nothing.
            if (count_next == 2'd2)
            begin
                job.bytes[0] = sextet_buf_next[11:4];
                job.nbytes   = 2'd1;
            end
            else if (count_next == 2'd3)
            begin
                job.bytes[0] = sextet_buf_next[17:10];
                job.bytes[1] = sextet_buf_next[9:2];
                job.nbytes   = 2'd2;
            end
            job.last        = 1'b1;
            sextet_buf_next = '0;
            count_next      = 2'd0;
            halted_next     = 1'b0;
        end

        job_push = accept && (job.nbytes != 2'd0 || job.last);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sextet_buf_reg <= '0;
            count_reg      <= '0;
            halted_reg     <= 1'b0;
        end
        else if (accept)
        begin
            sextet_buf_reg <= sextet_buf_next;
            count_reg      <= count_next;
            halted_reg     <= halted_next;
        end
    end

endmodule

### design/b64sd_queue.sv
// Short job queue between the decoder front end and back end.
// Uses b64sd_pkg for the job record.
module b64sd_queue import b64sd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  job_t wr_job,
    output logic q_full,
    input  logic rd_en,
    output job_t rd_job,
    output logic q_empty
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_CNT = CW'(QUEUE_DEPTH);

    job_t          slots_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign q_full  = (count_reg == DEPTH_CNT);
    assign q_empty = (count_reg == '0);
    assign rd_job  = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slots_reg[wr_ptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### design/b64sd_back.sv
// Back end of the base64 decoder (uses b64sd_pkg): turns job records into
// result beats via an output register, one per cycle unless held by pop.
module b64sd_back import b64sd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  job_t      head_job,
    input  logic      q_empty,
    output logic      q_pop,
    output logic      empty,
    input  logic      pop,
    output out_beat_t result
);

    job_t       job_reg;
    logic       job_valid_reg;
    logic [1:0] idx_reg;
    out_beat_t  out_reg, out_next;
    logic       out_valid_reg;

    logic       advance;
    logic       job_done;
    logic [1:0] last_idx;

    assign last_idx = (job_reg.nbytes == 2'd0) ? 2'd0 : job_reg.nbytes - 2'd1;
    assign advance  = job_valid_reg && (!out_valid_reg || pop);
    assign job_done = advance && (idx_reg == last_idx);
    assign q_pop    = !q_empty && (!job_valid_reg || job_done);
    assign empty    = !out_valid_reg;
    assign result   = out_reg;

    always_comb
    begin
        out_next.data_byte  = job_reg.bytes[idx_reg];
        out_next.byte_valid = (job_reg.nbytes != 2'd0);
        out_next.output_end = job_reg.last && (idx_reg == last_idx);
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            job_reg <= head_job;
        end
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                job_valid_reg <= 1'b1;
                idx_reg       <= '0;
            end
            else if (job_done)
            begin
                job_valid_reg <= 1'b0;
            end
            else if (advance)
            begin
                idx_reg <= idx_reg + 2'd1;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop && out_valid_reg)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

### design/base64_stream_decoder_top.sv
// Top level of the streaming base64 decoder.
// Instantiates b64sd_front, b64sd_queue and b64sd_back; uses b64sd_pkg.
//
// Usage: the input side is a queue write port. Each beat carries one character
// of an encoded string and a flag marking the string's final character. A beat
// is taken on a rising edge with push high and full low. The result side is a
// queue read port: while empty is low the oldest result beat sits on result,
// and it is taken on a rising edge with pop high.
// Each valid character adds a sextet; the fourth sextet of a group yields three
// bytes. The first '=' or other invalid character stops decoding until the end
// flag. At the end flag a partial group is flushed and the last result beat
// carries output_end; if nothing remains, a beat with byte_valid low carries it.
// A character's first result beat passes through the queue slot, the job
// register and the output register, in that order.
// Throughput: one character per cycle while the job queue has room; while pop
// is held high the result port delivers one byte per cycle, so a run of full
// groups (three bytes per four characters) streams without stalls. Holding
// off pop fills the queue, and full rises until space opens; nothing is lost.
// Reset clears the sextet buffer, halt flag, queue and output valid flag; the
// block accepts characters on the first cycle after reset is released.
module base64_stream_decoder_top import b64sd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  in_beat_t  item,
    output logic      empty,
    input  logic      pop,
    output out_beat_t result
);

    logic job_push;
    job_t job_in;
    logic queue_full;
    logic queue_empty;
    logic queue_pop;
    job_t head_job;

    b64sd_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .item       (item),
        .queue_full (queue_full),
        .job_push   (job_push),
        .job        (job_in)
    );

    b64sd_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_job  (job_in),
        .q_full  (queue_full),
        .rd_en   (queue_pop),
        .rd_job  (head_job),
        .q_empty (queue_empty)
    );

    b64sd_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .head_job (head_job),
        .q_empty  (queue_empty),
        .q_pop    (queue_pop),
        .empty    (empty),
        .pop      (pop),
        .result   (result)
    );

endmodule

### bench/tb_base64_stream_decoder_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for base64_stream_decoder_top: directed and random
// strings. Depends on b64sd_pkg for the beat types and character constants.
module tb_base64_stream_decoder_top;
    import b64sd_pkg::*;

    // The '=' padding character; it halts decoding just like any other byte
    // outside the alphabet.
    localparam logic [7:0] CHAR_PAD = 8'h3D;

    // Longest run of cycles without any beat moving before the run is declared
    // hung.
    localparam int STALL_LIMIT = 2000;

    // Minimum number of random characters to send after the directed strings.
    localparam int RANDOM_CHARS = 155;

    // Cycles to keep watching the result port after the last expected beat.
    localparam int DRAIN_CYCLES = 12;

    // The scoreboard carries its own copy of the decoder state and turns every
    // accepted character into the result beats it should produce. Those beats
    // wait in expected_bytes until the result port delivers them in order.
    class decode_scoreboard;
        logic [17:0] sextet_acc;
        logic [1:0]  sextets_held;
        bit          halted;
        out_beat_t   expected_bytes[$];
        int          errors;
        int          chars_seen;
        int          strings_seen;
        int          bytes_checked;
        int          markers_checked;

        function new();
            sextet_acc = '0;
            sextets_held = '0;
            halted = 1'b0;
            errors = 0;
            chars_seen = 0;
            strings_seen = 0;
            bytes_checked = 0;
            markers_checked = 0;
        endfunction

        // Six-bit value of an alphabet character, or -1 for '=' and every
        // other byte outside the alphabet.
        function int sextet_value(input logic [7:0] c);
            if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
            begin
                return int'(c - CHAR_UPPER_A);
            end
            if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z)
            begin
                return int'(c - CHAR_LOWER_A) + 26;
            end
            if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9)
            begin
                return int'(c - CHAR_DIGIT_0) + 52;
            end
            if (c == CHAR_PLUS)
            begin
                return 62;
            end
            if (c == CHAR_SLASH)
            begin
                return 63;
            end
            return -1;
        endfunction

        function void push_byte(ref out_beat_t fresh[$], input logic [7:0] b);
            out_beat_t beat;
            beat.data_byte = b;
            beat.byte_valid = 1'b1;
            beat.output_end = 1'b0;
            fresh.push_back(beat);
        endfunction

        // Predicts the result beats of one accepted character.
        function void note_char(input in_beat_t ch);
            out_beat_t   fresh[$];
            out_beat_t   beat;
            logic [23:0] word;
            int          v;

            chars_seen++;
            if (!halted)
            begin
                v = sextet_value(ch.char_code);
                if (v < 0)
                begin
                    halted = 1'b1;
                end
                else if (sextets_held == 2'd3)
                begin
                    // The fourth sextet completes a group of three bytes.
                    word = {sextet_acc, 6'(v)};
                    push_byte(fresh, word[23:16]);
                    push_byte(fresh, word[15:8]);
                    push_byte(fresh, word[7:0]);
                    sextet_acc = '0;
                    sextets_held = '0;
                end
                else
                begin
                    sextet_acc = {sextet_acc[11:0], 6'(v)};
                    sextets_held = sextets_held + 2'd1;
                end
            end

            if (ch.string_end)
            begin
                strings_seen++;
                // A partial group of k sextets flushes k-1 bytes; a single
                // leftover sextet gives nothing.
                if (sextets_held == 2'd2)
                begin
                    push_byte(fresh, sextet_acc[11:4]);
                end
                else if (sextets_held == 2'd3)
                begin
                    push_byte(fresh, sextet_acc[17:10]);
                    push_byte(fresh, sextet_acc[9:2]);
                end
                if (fresh.size() == 0)
                begin
                    beat.data_byte = 8'h00;
                    beat.byte_valid = 1'b0;
                    beat.output_end = 1'b1;
                end
                else
                begin
                    beat = fresh.pop_back();
                    beat.output_end = 1'b1;
                end
                fresh.push_back(beat);
                sextet_acc = '0;
                sextets_held = '0;
                halted = 1'b0;
            end

            foreach (fresh[i])
            begin
                expected_bytes.push_back(fresh[i]);
            end
        endfunction

        // Compares one accepted result beat with the oldest prediction.
        function void check_byte(input out_beat_t got);
            out_beat_t want;

            if (expected_bytes.size() == 0)
            begin
                $error("unexpected result beat: data_byte %0h byte_valid %0b output_end %0b",
                       got.data_byte, got.byte_valid, got.output_end);
                errors++;
                return;
            end
            want = expected_bytes.pop_front();
            // An empty end marker carries a zero byte.
            if (got.data_byte !== want.data_byte)
            begin
                $error("data_byte mismatch: expected %0h actual %0h",
                       want.data_byte, got.data_byte);
                errors++;
            end
            if (got.byte_valid !== want.byte_valid)
            begin
                $error("byte_valid mismatch: expected %0b actual %0b",
                       want.byte_valid, got.byte_valid);
                errors++;
            end
            if (got.output_end !== want.output_end)
            begin
                $error("output_end mismatch: expected %0b actual %0b",
                       want.output_end, got.output_end);
                errors++;
            end
            if (want.byte_valid)
            begin
                bytes_checked++;
            end
            else
            begin
                markers_checked++;
            end
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      push;
    logic      full;
    in_beat_t  item;
    logic      empty;
    logic      pop;
    out_beat_t result;

    decode_scoreboard sb;

    // While a burst flag is set, the matching side offers a beat every cycle;
    // otherwise it draws a random idle gap before each beat.
    bit tx_burst;
    bit rx_burst;
    int chars_sent;
    int stall_cycles;

    base64_stream_decoder_top dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Watchdog: a hung block shows up as a long stretch with no beat moving
    // on either port.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
            begin
                stall_cycles = 0;
            end
            else
            begin
                stall_cycles++;
            end
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no beat moved for %0d cycles", STALL_LIMIT);
                $display("tb_base64_stream_decoder_top failed");
                $finish;
            end
        end
    end

    // Sends one character beat. It is entered and left on a falling edge.
    // Push is only lowered when there really is an idle gap, so a back-to-back
    // beat never sees push dropped and raised within the same time step.
    task automatic send_char(input logic [7:0] c, input logic fin);
        in_beat_t beat;
        int       gap;

        beat.char_code = c;
        beat.string_end = fin;
        gap = tx_burst ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        push <= 1'b1;
        item <= beat;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        sb.note_char(beat);
        chars_sent++;
        @(negedge clk);
    endtask

    // Sends a whole string; the last character carries the end flag.
    task automatic send_string(input logic [7:0] chars[$]);
        foreach (chars[i])
        begin
            send_char(chars[i], i == chars.size() - 1);
        end
    endtask

    task automatic send_text(input string s);
        logic [7:0] chars[$];

        for (int i = 0; i < s.len(); i++)
        begin
            chars.push_back(s[i]);
        end
        send_string(chars);
    endtask

    function automatic logic [7:0] alphabet_char(input int v);
        if (v < 26)
        begin
            return CHAR_UPPER_A + 8'(v);
        end
        if (v < 52)
        begin
            return CHAR_LOWER_A + 8'(v - 26);
        end
        if (v < 62)
        begin
            return CHAR_DIGIT_0 + 8'(v - 52);
        end
        return (v == 62) ? CHAR_PLUS : CHAR_SLASH;
    endfunction

    // Builds one random string. Most strings are well-formed encodings with
    // random content: whole groups only, a padded tail or a bare partial tail;
    // the rest are valid text with a stray byte dropped in, or plain byte noise.
    task automatic send_random_string();
        logic [7:0] chars[$];
        int         kind;
        int         groups;
        int         tail;
        int         len;
        int         spot;

        kind = $urandom_range(0, 9);
        if (kind <= 5)
        begin
            groups = $urandom_range(0, 3);
            tail = $urandom_range(0, 3);
            for (int i = 0; i < groups * 4 + tail; i++)
            begin
                chars.push_back(alphabet_char($urandom_range(0, 63)));
            end
            // Pad a partial group out to four characters half of the time.
            if (tail != 0 && $urandom_range(0, 1))
            begin
                for (int i = tail; i < 4; i++)
                begin
                    chars.push_back(CHAR_PAD);
                end
            end
            if (chars.size() == 0)
            begin
                chars.push_back(alphabet_char($urandom_range(0, 63)));
            end
        end
        else if (kind <= 7)
        begin
            len = $urandom_range(1, 10);
            for (int i = 0; i < len; i++)
            begin
                chars.push_back(alphabet_char($urandom_range(0, 63)));
            end
            spot = $urandom_range(0, len - 1);
            chars[spot] = 8'($urandom_range(0, 255));
        end
        else
        begin
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++)
            begin
                chars.push_back(8'($urandom_range(0, 255)));
            end
        end
        send_string(chars);
    endtask

    // Result side: pops beats with random holds and checks each one as it is
    // accepted. It runs until the main sequence ends the simulation.
    initial
    begin
        int gap;

        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if ($urandom_range(0, 15) == 0)
            begin
                rx_burst = !rx_burst;
            end
            gap = rx_burst ? 0 : $urandom_range(0, 19);
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty)
            begin
                @(posedge clk);
            end
            sb.check_byte(result);
            @(negedge clk);
        end
    end

    initial
    begin
        int directed_chars;

        sb = new();
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        item = '0;
        tx_burst = 1'b0;
        rx_burst = 1'b0;
        chars_sent = 0;
        stall_cycles = 0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed strings. The first covers the alphabet extremes in two full
        // groups, the last group completed by the final character.
        send_text("+/09AZaz");
        // One pad: three sextets flush two bytes.
        send_text("TWE=");
        // Two pads: two sextets flush one byte.
        send_text("TQ==");
        // A single leftover sextet gives no byte, only an empty end marker.
        send_text("T");
        // Halted at once with nothing decoded: an empty end marker.
        send_text("=");
        // A high byte halts decoding; the following characters, including a
        // zero byte that ends the string, are ignored.
        send_char(8'h61, 1'b0);
        send_char(8'h62, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(8'h63, 1'b0);
        send_char(8'h00, 1'b1);
        directed_chars = chars_sent;

        // Random strings, with the sender sometimes running back to back.
        while (chars_sent < directed_chars + RANDOM_CHARS)
        begin
            tx_burst = ($urandom_range(0, 3) == 0);
            send_random_string();
        end
        push <= 1'b0;

        // Let every predicted beat arrive, then watch a little longer for any
        // stray beat. The watchdog bounds this wait.
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d characters in %0d strings.", sb.chars_seen, sb.strings_seen);
        $display("Checked %0d decoded bytes and %0d empty end markers.",
                 sb.bytes_checked, sb.markers_checked);
        if (sb.errors == 0)
        begin
            $display("tb_base64_stream_decoder_top passed");
        end
        else
        begin
            $display("%0d mismatches found", sb.errors);
            $display("tb_base64_stream_decoder_top failed");
        end
        $finish;
    end

endmodule
